>>> rtl/dqvr_pkg.sv
// Package for the deque with value removal: widths, command codes and the cell control struct.
package dqvr_pkg;

   localparam int VALUE_W          = 32;
   localparam int CMD_W            = 3;
   localparam int COUNT_OUT_W      = 7;
   localparam int CAPACITY_DEFAULT = 64;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd4;

   // control broadcast from the sequencer to every cell of the row
   typedef struct packed {
      logic               compare;  // capture match and back-end tap
      logic               commit;   // apply a successful command
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] val;
   } cell_ctrl_type;

endpackage

>>> rtl/dqvr_if.sv
// Request and response channel interfaces of the deque.
interface dqvr_req_if;
   logic                                valid;
   logic                                ready;
   logic [dqvr_pkg::CMD_W-1:0]          command;
   logic signed [dqvr_pkg::VALUE_W-1:0] value;

   modport source (output valid, command, value, input ready);
   modport sink   (input valid, command, value, output ready);
endinterface

interface dqvr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    ok;
   logic signed [dqvr_pkg::VALUE_W-1:0]     popped_value;
   logic [dqvr_pkg::COUNT_OUT_W-1:0]        entry_count;

   modport source (output valid, ok, popped_value, entry_count, input ready);
   modport sink   (input valid, ok, popped_value, entry_count, output ready);
endinterface

>>> rtl/deque_with_value_removal.sv
// Top level of the deque with value removal: sequencer, count and the row of cells.
//
//   channel  direction  payload                            transfer
//   req      in         command, value                     valid && ready
//   rsp      out        ok, popped_value, entry_count      valid && ready
//
// Each request goes through three steps: accept, compare across all cells, commit.
// The compare and commit steps act on the row of cells, which all match
// and shift in parallel; a new request is taken once the commit is done.
// Reset clears the entry count, the sequencer and the response valid; slot contents stay unknown.
// A stalled response holds the commit of the next request until it is taken.
module deque_with_value_removal #(
   parameter int CAPACITY = dqvr_pkg::CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dqvr_req_if.sink   req,
   dqvr_rsp_if.source rsp
);
   import dqvr_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [CMD_W-1:0]       cmd_ff;
   logic [VALUE_W-1:0]     val_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff, ok_in;
   logic [VALUE_W-1:0]     popped_ff, popped_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [COUNT_W+COUNT_OUT_W-1:0] count_wide;

   cell_ctrl_type      ctrl;
   logic               load;
   logic               found;
   logic               full;
   logic               empty;
   logic [VALUE_W-1:0] back_val;
   logic [CAPACITY-1:0] hits;
   logic [CAPACITY-1:0] sweep;
   logic [VALUE_W-1:0] cell_data [CAPACITY];
   logic [VALUE_W-1:0] cell_tap  [CAPACITY];

   assign req.ready = state_ff == ST_IDLE;
   assign load      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);
   assign full      = count_ff == COUNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign found     = |hits;

   // hold the accepted request
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cmd_ff <= req.command;
         val_ff <= req.value;
      end
   end

   // advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_CMP;
         ST_CMP:  state_in = ST_EXEC;
         ST_EXEC: if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // decide the outcome of the command and the new count
   always_comb begin
      ok_in     = 1'b0;
      popped_in = '0;
      count_in  = count_ff;
      case (cmd_ff)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            ok_in = !full;
            if (!full) count_in = count_ff + COUNT_W'(1);
         end
         CMD_POP_FRONT: begin
            ok_in = !empty;
            if (!empty) begin
               popped_in = cell_data[0];
               count_in  = count_ff - COUNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            ok_in = !empty;
            if (!empty) begin
               popped_in = back_val;
               count_in  = count_ff - COUNT_W'(1);
            end
         end
         CMD_REMOVE_FIRST: begin
            ok_in = found;
            if (found) count_in = count_ff - COUNT_W'(1);
         end
         default: ok_in = 1'b0;
      endcase
   end

   assign ctrl.compare = state_ff == ST_CMP;
   assign ctrl.commit  = load && ok_in;
   assign ctrl.cmd     = cmd_ff;
   assign ctrl.val     = val_ff;

   // combine the back-end taps; only the last occupied cell is nonzero
   always_comb begin
      back_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_val = back_val | cell_tap[i];
      end
   end

   // row of cells, each shifting toward the front or back with its neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = val_ff;
      end else begin : g_mid_l
         assign left_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_mid_r
         assign right_data = cell_data[g+1];
      end

      // the first match and every cell behind it close the gap
      assign sweep[g] = |hits[g:0];

      dqvr_cell #(
         .INDEX   (g),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .sweep      (sweep[g]),
         .data       (cell_data[g]),
         .hit        (hits[g]),
         .tap        (cell_tap[g])
      );
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) count_ff <= count_in;
      end
   end

   // hold the response payload
   assign count_wide = (COUNT_W + COUNT_OUT_W)'(count_in);

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff        <= ok_in;
         popped_ff    <= popped_in;
         rsp_count_ff <= count_wide[COUNT_OUT_W-1:0];
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.ok           = ok_ff;
   assign rsp.popped_value = popped_ff;
   assign rsp.entry_count  = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response overwritten before it was taken");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (load && ok_in && (cmd_ff == CMD_PUSH_FRONT || cmd_ff == CMD_PUSH_BACK))
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("successful push did not grow the count");

   a_accept_to_compare : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == ST_CMP)
      else $error("accepted request did not start a compare");
`endif

endmodule

>>> rtl/dqvr_cell.sv
// One slot of the deque: holds a value, shifts with its neighbors and flags a match.
module dqvr_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 7
) (
   input  logic                           clock,
   input  dqvr_pkg::cell_ctrl_type        ctrl,
   input  logic [COUNT_W-1:0]             count,
   input  logic [dqvr_pkg::VALUE_W-1:0]   left_data,
   input  logic [dqvr_pkg::VALUE_W-1:0]   right_data,
   input  logic                           sweep,
   output logic [dqvr_pkg::VALUE_W-1:0]   data,
   output logic                           hit,
   output logic [dqvr_pkg::VALUE_W-1:0]   tap
);
   import dqvr_pkg::*;

   logic [VALUE_W-1:0] data_ff, data_in;
   logic               hit_ff;
   logic [VALUE_W-1:0] tap_ff;
   logic               occupied;
   logic               is_last;
   logic               at_count;

   assign occupied = COUNT_W'(INDEX) < count;
   assign is_last  = count == COUNT_W'(INDEX + 1);
   assign at_count = count == COUNT_W'(INDEX);

   // pick the next value of the slot for a committed command
   always_comb begin
      data_in = data_ff;
      if (ctrl.commit) begin
         case (ctrl.cmd)
            CMD_PUSH_FRONT:   data_in = left_data;
            CMD_PUSH_BACK:    if (at_count) data_in = ctrl.val;
            CMD_POP_FRONT:    data_in = right_data;
            CMD_REMOVE_FIRST: if (sweep) data_in = right_data;
            default:          data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // capture the match flag and the back-end value during the compare cycle
   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         hit_ff <= occupied && (data_ff == ctrl.val);
         tap_ff <= is_last ? data_ff : '0;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;
   assign tap  = tap_ff;

endmodule

>>> verif/deque_with_value_removal_checker.sv
// Checker for the deque with value removal: shadow queue, reply prediction and compare.
`timescale 1ns / 100ps

module deque_with_value_removal_checker #(
   parameter int CAPACITY = dqvr_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [dqvr_pkg::CMD_W-1:0]          req_command,
   input  logic signed [dqvr_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_ok,
   input  logic signed [dqvr_pkg::VALUE_W-1:0] rsp_popped_value,
   input  logic [dqvr_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output int                                  error_count,
   output int                                  pending_count
);
   import dqvr_pkg::*;

   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] popped;
      logic [COUNT_OUT_W-1:0]    count;
   } reply_type;

   // front of the queue is index 0, back is the last index
   logic signed [VALUE_W-1:0] shadow_entries[$];
   reply_type                 expected_replies[$];

   // apply one request to the shadow queue and return the reply it yields
   function automatic reply_type apply_request(input logic [CMD_W-1:0] cmd,
                                               input logic signed [VALUE_W-1:0] val);
      reply_type reply;
      int        idx;
      reply = '0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (shadow_entries.size() < CAPACITY) begin
               shadow_entries.push_front(val);
               reply.ok = 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (shadow_entries.size() < CAPACITY) begin
               shadow_entries.push_back(val);
               reply.ok = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_entries.size() > 0) begin
               reply.popped = shadow_entries.pop_front();
               reply.ok     = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_entries.size() > 0) begin
               reply.popped = shadow_entries.pop_back();
               reply.ok     = 1'b1;
            end
         end
         CMD_REMOVE_FIRST: begin
            // drop the earliest match; later entries close the gap
            for (idx = 0; idx < shadow_entries.size() && !reply.ok; idx++) begin
               if (shadow_entries[idx] == val) begin
                  shadow_entries.delete(idx);
                  reply.ok = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      reply.count = COUNT_OUT_W'(shadow_entries.size());
      return reply;
   endfunction

   // predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         shadow_entries.delete();
         expected_replies.delete();
         error_count = 0;
      end else begin
         if (req_valid && req_ready)
            expected_replies.push_back(apply_request(req_command, req_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected: ok=%0b popped=%0d count=%0d",
                        $time, rsp_ok, rsp_popped_value, rsp_entry_count);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ok !== want.ok) begin
                  error_count++;
                  $display("%0t: ok mismatch: expected %0b, actual %0b",
                           $time, want.ok, rsp_ok);
               end
               if (rsp_popped_value !== want.popped) begin
                  error_count++;
                  $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                           $time, want.popped, rsp_popped_value);
               end
               if (rsp_entry_count !== want.count) begin
                  error_count++;
                  $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                           $time, want.count, rsp_entry_count);
               end
            end
         end
      end
      pending_count = expected_replies.size();
   end

endmodule

>>> verif/deque_with_value_removal_test.sv
// Testbench top for the deque with value removal: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module deque_with_value_removal_test;
   import dqvr_pkg::*;

   localparam int DEPTH        = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   // command codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_SPARE_A = CMD_REMOVE_FIRST + 3'd1;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = CMD_REMOVE_FIRST + 3'd2;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = CMD_REMOVE_FIRST + 3'd3;

   typedef enum int {PHASE_FILL, PHASE_REMOVE, PHASE_DRAIN, PHASE_MIXED} phase_type;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   pending_count;
   int   cycle_count = 0;
   logic no_gaps = 1'b0;

   dqvr_req_if req_ch();
   dqvr_rsp_if rsp_ch();

   deque_with_value_removal #(.CAPACITY(DEPTH)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   deque_with_value_removal_checker #(.CAPACITY(DEPTH)) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_command      (req_ch.command),
      .req_value        (req_ch.value),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_ok           (rsp_ch.ok),
      .rsp_popped_value (rsp_ch.popped_value),
      .rsp_entry_count  (rsp_ch.entry_count),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL deque_with_value_removal");
         $finish;
      end
   end

   // mostly short idle stretches, a few long ones
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small pool so removals hit, plus extremes and full-range values
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return $urandom_range(0, 7) - 4;
      if (pick < 65) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   // command mix for each phase of traffic
   function automatic logic [CMD_W-1:0] pick_command(input phase_type phase);
      int               pick;
      logic [CMD_W-1:0] push_cmd;
      logic [CMD_W-1:0] pop_cmd;
      pick     = $urandom_range(0, 99);
      push_cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      pop_cmd  = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      if (pick < 4) begin
         case ($urandom_range(0, 2))
            0: return CMD_SPARE_A;
            1: return CMD_SPARE_B;
            default: return CMD_SPARE_C;
         endcase
      end
      case (phase)
         PHASE_FILL:   return (pick < 92) ? push_cmd : pop_cmd;
         PHASE_REMOVE: begin
            if (pick < 45) return push_cmd;
            if (pick < 85) return CMD_REMOVE_FIRST;
            return pop_cmd;
         end
         PHASE_DRAIN:  begin
            if (pick < 74) return pop_cmd;
            if (pick < 92) return CMD_REMOVE_FIRST;
            return push_cmd;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: return CMD_PUSH_FRONT;
               1: return CMD_PUSH_BACK;
               2: return CMD_POP_FRONT;
               3: return CMD_POP_BACK;
               default: return CMD_REMOVE_FIRST;
            endcase
         end
      endcase
   endfunction

   // idle, then hold the request until it is taken
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [VALUE_W-1:0] val);
      int gap;
      gap = no_gaps ? 0 : gap_length();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.value   <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // response back-pressure: ready bursts broken by stalls
   initial begin
      int on_len;
      int off_len;
      rsp_ch.ready = 1'b0;
      forever begin
         on_len  = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 8);
         off_len = gap_length();
         repeat (on_len) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
         repeat (off_len) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // request traffic and verdict
   initial begin
      int        sent;
      int        run_len;
      int        k;
      phase_type phase;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_PUSH_FRONT;
      req_ch.value   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue: both pops and a removal miss
      send_request(CMD_POP_FRONT, 32'sd0);
      send_request(CMD_POP_BACK, -32'sd1);
      send_request(CMD_REMOVE_FIRST, 32'sd0);
      // both ends with extremes and a duplicate value
      send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(CMD_PUSH_BACK, 32'sh8000_0000);
      send_request(CMD_PUSH_BACK, 32'sd5);
      send_request(CMD_PUSH_FRONT, 32'sd5);
      send_request(CMD_PUSH_BACK, -32'sd1);
      send_request(CMD_PUSH_FRONT, 32'sd0);
      // earliest duplicate goes, then a missed match
      send_request(CMD_REMOVE_FIRST, 32'sd5);
      send_request(CMD_REMOVE_FIRST, 32'sd9);
      send_request(CMD_POP_FRONT, 32'sd0);
      send_request(CMD_POP_BACK, 32'sd0);
      // ignored commands
      send_request(CMD_SPARE_A, 32'sd5);
      send_request(CMD_SPARE_B, 32'sh7fff_ffff);
      send_request(CMD_SPARE_C, -32'sd1);
      // removal in the middle, then run dry
      send_request(CMD_REMOVE_FIRST, 32'sh8000_0000);
      send_request(CMD_POP_FRONT, 32'sd0);
      send_request(CMD_POP_BACK, 32'sd0);
      send_request(CMD_POP_FRONT, 32'sd0);
      send_request(CMD_POP_BACK, 32'sd0);

      // random phases: fill past full, churn with removals, drain past empty, mix
      sent  = 0;
      phase = PHASE_FILL;
      while (sent < RANDOM_ITEMS) begin
         run_len = $urandom_range(90, 140);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
            send_request(pick_command(phase), pick_value());
            sent++;
         end
         case (phase)
            PHASE_FILL:   phase = PHASE_REMOVE;
            PHASE_REMOVE: phase = PHASE_DRAIN;
            PHASE_DRAIN:  phase = PHASE_MIXED;
            default:      phase = PHASE_FILL;
         endcase
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS deque_with_value_removal");
      end else begin
         $display("FAIL deque_with_value_removal");
      end
      $finish;
   end

endmodule
